// ----- rtl/wildcard_byte_pattern_search_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/wbps_pkg.sv -----
package wbps_pkg;

    // Pattern depth and byte offset range
    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;
    localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);

    // Byte counter saturates at the smaller of 2^OFFSET_BITS-1 and 2^32-1
    localparam int CNT_W = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

    // Fixed field widths
    localparam int LEN_W   = 6;
    localparam int MAX_W   = 16;
    localparam int ADDR_W  = 48;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 5;
    localparam int CFG_W   = 48;
    localparam int CFG_A_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        REG_PATTERN_LEN  = 2'd0,
        REG_MAX_MATCHES  = 2'd1,
        REG_SECTION_BASE = 2'd2
    } cfg_reg_t;

    // Item actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SCAN = 1'b1;

    // One pattern position
    typedef struct packed {
        logic              wild;
        logic [BYTE_W-1:0] value;
    } pat_entry_t;

    typedef pat_entry_t [MAX_PATTERN-1:0] pat_vec_t;

    // Scan item handed from the byte counter logic to the report stage
    typedef struct packed {
        logic             last;
        logic             check;
        logic [CNT_W-1:0] offset;
    } scan_tok_t;

endpackage

// ----- rtl/wbps_cell.sv -----
// One window position: holds a byte, passes it on, and flags a hit for
// the byte it takes in against its aligned pattern position.
module wbps_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic                          clear,
    input  logic [wbps_pkg::BYTE_W-1:0]   in_byte,
    input  wbps_pkg::pat_entry_t          pat,
    input  logic                          active,
    output logic [wbps_pkg::BYTE_W-1:0]   out_byte,
    output logic                          hit
);

    logic [wbps_pkg::BYTE_W-1:0] byte_reg;
    logic [wbps_pkg::BYTE_W-1:0] byte_next;
    logic                        hit_reg;
    logic                        hit_next;

    always_comb
    begin
        byte_next = byte_reg;
        hit_next  = hit_reg;
        if (shift_en)
        begin
            byte_next = clear ? '0 : in_byte;
            // positions outside the pattern length always pass
            hit_next  = !active || pat.wild || (in_byte == pat.value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign out_byte = byte_reg;
    assign hit      = hit_reg;

endmodule

// ----- rtl/wbps_report.sv -----
// Match decision, per-section match count and output register.
module wbps_report
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  tok_load,
    input  wbps_pkg::scan_tok_t                   tok,
    input  logic [wbps_pkg::MAX_PATTERN-1:0]      hits,
    input  logic [wbps_pkg::MAX_W-1:0]            max_matches,
    input  logic [wbps_pkg::ADDR_W-1:0]           section_base,
    output logic                                  tok_ready,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic [wbps_pkg::ADDR_W-1:0]           match_address,
    output logic                                  done_res,
    output logic [wbps_pkg::MAX_W-1:0]            match_count
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    wbps_pkg::scan_tok_t           tok_reg;
    logic [wbps_pkg::MAX_W-1:0]    count_reg;
    logic [wbps_pkg::MAX_W-1:0]    count_next;
    logic [wbps_pkg::MAX_W-1:0]    count_inc;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          found_reg;
    logic [wbps_pkg::ADDR_W-1:0]   addr_reg;
    logic                          done_reg;
    logic [wbps_pkg::MAX_W-1:0]    mcount_reg;

    logic                          hit_now;
    logic                          emit;
    logic                          go;
    logic                          out_free;
    logic [wbps_pkg::ADDR_W-1:0]   addr_now;

    assign hit_now   = s1_valid_reg && tok_reg.check && (&hits) && (count_reg < max_matches);
    assign emit      = hit_now || tok_reg.last;
    assign out_free  = !out_valid_reg || !out_stall;
    assign go        = s1_valid_reg && (!emit || out_free);
    assign tok_ready = !s1_valid_reg || go;
    assign count_inc = count_reg + {{(wbps_pkg::MAX_W-1){1'b0}}, hit_now};
    assign addr_now  = section_base
                     + {{(wbps_pkg::ADDR_W-wbps_pkg::CNT_W){1'b0}}, tok_reg.offset};

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tok_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end

        count_next = count_reg;
        if (go)
        begin
            count_next = tok_reg.last ? '0 : count_inc;
        end

        out_valid_next = out_valid_reg;
        if (go && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_load)
        begin
            tok_reg <= tok;
        end
        if (go && emit)
        begin
            found_reg  <= hit_now;
            addr_reg   <= hit_now ? addr_now : '0;
            done_reg   <= tok_reg.last;
            mcount_reg <= count_inc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;
    assign done_res      = done_reg;
    assign match_count   = mcount_reg;

endmodule

// ----- rtl/wildcard_byte_pattern_search_core.sv -----
// Result path: a scan item's token and cell hits are registered when the item
//   is accepted; the report stage then registers the result for the outputs.
// Throughput: 1 item per cycle while the output is not stalled; the cell row
//   shifts one byte per scan item, the report stage one scan item per cycle.
// Output stall holds the report stage, then the input, one item at a time.
// Reset: async active low; clears window, counters, config (len 1, limit 1,
//   base 0); pattern entries hold garbage until loaded.
module wildcard_byte_pattern_search_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write port
    input  logic                                  cfg_we,
    input  logic [wbps_pkg::CFG_A_W-1:0]          cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]            cfg_data,

    // input item channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [wbps_pkg::IDX_W-1:0]            entry_index,
    input  logic [wbps_pkg::BYTE_W-1:0]           entry_byte,
    input  logic                                  entry_wild,
    input  logic [wbps_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                  is_last,

    // result item channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic [wbps_pkg::ADDR_W-1:0]           match_address,
    output logic                                  done_res,
    output logic [wbps_pkg::MAX_W-1:0]            match_count
);

    localparam logic [wbps_pkg::CNT_W-1:0] CNT_MAX = '1;

    // Config registers
    logic [wbps_pkg::LEN_W-1:0]    pattern_len_reg;
    logic [wbps_pkg::MAX_W-1:0]    max_matches_reg;
    logic [wbps_pkg::ADDR_W-1:0]   section_base_reg;

    // Pattern store: written by load items, read through the aligner
    wbps_pkg::pat_vec_t            pat_reg;
    wbps_pkg::pat_vec_t            pat_aligned;

    // Byte counter for the current section
    logic [wbps_pkg::CNT_W-1:0]    seen_reg;
    logic [wbps_pkg::CNT_W-1:0]    seen_next;
    logic [wbps_pkg::CNT_W-1:0]    seen_inc;
    logic [wbps_pkg::CNT_W-1:0]    len_ext;
    logic                          can_check;
    logic                          len_ok;

    logic                          in_acc;
    logic                          scan_acc;
    logic                          load_acc;
    logic                          tok_ready;
    wbps_pkg::scan_tok_t           tok;

    logic [wbps_pkg::BYTE_W-1:0]   win_byte [wbps_pkg::MAX_PATTERN];
    logic [wbps_pkg::MAX_PATTERN-1:0] cell_hit;

    // Rotate the pattern so that cell k sees entry (k + len) mod depth.
    // With the newest byte in the last cell, pattern entry i then lines up
    // with window position depth - len + i.
    function automatic wbps_pkg::pat_vec_t align_pattern(
        input wbps_pkg::pat_vec_t               pat,
        input logic [wbps_pkg::PAT_IDX_W-1:0]   amt
    );
        wbps_pkg::pat_vec_t cur;
        wbps_pkg::pat_vec_t nxt;
        cur = pat;
        for (int b = 0; b < wbps_pkg::PAT_IDX_W; b++)
        begin
            for (int k = 0; k < wbps_pkg::MAX_PATTERN; k++)
            begin
                nxt[k] = amt[b] ? cur[(k + (1 << b)) % wbps_pkg::MAX_PATTERN] : cur[k];
            end
            cur = nxt;
        end
        return cur;
    endfunction

    assign in_stall = !tok_ready;
    assign in_acc   = in_valid && !in_stall;
    assign scan_acc = in_acc && (action == wbps_pkg::ACT_SCAN);
    assign load_acc = in_acc && (action == wbps_pkg::ACT_LOAD);

    assign pat_aligned = align_pattern(pat_reg, pattern_len_reg[wbps_pkg::PAT_IDX_W-1:0]);

    // Counter and offset of the match start for this byte
    assign len_ext   = {{(wbps_pkg::CNT_W-wbps_pkg::LEN_W){1'b0}}, pattern_len_reg};
    assign len_ok    = (pattern_len_reg != '0) && (pattern_len_reg <= wbps_pkg::MAX_PATTERN);
    assign can_check = (seen_reg != CNT_MAX);
    assign seen_inc  = seen_reg + 1'b1;

    always_comb
    begin
        seen_next = seen_reg;
        if (scan_acc)
        begin
            if (is_last)
            begin
                seen_next = '0;
            end
            else if (can_check)
            begin
                seen_next = seen_inc;
            end
        end
    end

    // a saturated counter means the byte is shifted in but never checked
    assign tok.last   = is_last;
    assign tok.check  = can_check && len_ok && (seen_inc >= len_ext);
    assign tok.offset = seen_inc - len_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg  <= wbps_pkg::LEN_W'(1);
            max_matches_reg  <= wbps_pkg::MAX_W'(1);
            section_base_reg <= '0;
            seen_reg         <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    wbps_pkg::REG_PATTERN_LEN:
                    begin
                        pattern_len_reg <= cfg_data[wbps_pkg::LEN_W-1:0];
                    end
                    wbps_pkg::REG_MAX_MATCHES:
                    begin
                        max_matches_reg <= cfg_data[wbps_pkg::MAX_W-1:0];
                    end
                    wbps_pkg::REG_SECTION_BASE:
                    begin
                        section_base_reg <= cfg_data[wbps_pkg::ADDR_W-1:0];
                    end
                    default:
                    begin
                        // unused index: write is dropped
                    end
                endcase
            end
        end
    end

    // Pattern entries have no reset value
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            pat_reg[entry_index[wbps_pkg::PAT_IDX_W-1:0]] <= '{wild: entry_wild,
                                                               value: entry_byte};
        end
    end

    // Row of window cells; the newest byte enters the last cell and every
    // byte moves one cell toward cell 0 per scan item.
    for (genvar k = 0; k < wbps_pkg::MAX_PATTERN; k++)
    begin : g_cell
        logic [wbps_pkg::BYTE_W-1:0] cell_in;
        logic                        cell_active;

        if (k == wbps_pkg::MAX_PATTERN - 1)
        begin : g_head
            assign cell_in = data_byte;
        end
        else
        begin : g_link
            assign cell_in = win_byte[k+1];
        end

        // cell k is inside the pattern when k >= depth - len
        assign cell_active = (32'(pattern_len_reg) + k) >= wbps_pkg::MAX_PATTERN;

        wbps_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (scan_acc),
            .clear    (is_last),
            .in_byte  (cell_in),
            .pat      (pat_aligned[k]),
            .active   (cell_active),
            .out_byte (win_byte[k]),
            .hit      (cell_hit[k])
        );
    end

    wbps_report u_report
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_load      (scan_acc),
        .tok           (tok),
        .hits          (cell_hit),
        .max_matches   (max_matches_reg),
        .section_base  (section_base_reg),
        .tok_ready     (tok_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address),
        .done_res      (done_res),
        .match_count   (match_count)
    );

endmodule

// ----- rtl/wbps_checker.sv -----
`include "wildcard_byte_pattern_search_core_defines.svh"

// Port-level checks on the result channel.
module wbps_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic                                  found,
    input  logic [wbps_pkg::ADDR_W-1:0]           match_address,
    input  logic                                  done_res,
    input  logic [wbps_pkg::MAX_W-1:0]            match_count
);

    // a result that is not a match must close the section
    `WBPS_ASSERT_SAME(a_result_has_reason, out_valid && !found, done_res, "empty result item")

    // no match means no address
    `WBPS_ASSERT_SAME(a_nomatch_addr_zero, out_valid && !found, match_address == '0, "stray address")

    // a reported match always counts itself
    `WBPS_ASSERT_SAME(a_match_counted, out_valid && found, match_count != '0, "match not counted")

    // stalled result holds
    `WBPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(match_address) && $stable(match_count), "stalled result changed")

endmodule

bind wildcard_byte_pattern_search_core wbps_checker u_wbps_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address),
    .done_res      (done_res),
    .match_count   (match_count)
);
